>>> rtl/autotile_neighbour_lookup_macros.svh
// Assertion macros shared by the autotile neighbour lookup RTL.
`ifndef AUTOTILE_NEIGHBOUR_LOOKUP_MACROS_SVH
`define AUTOTILE_NEIGHBOUR_LOOKUP_MACROS_SVH
`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define ANL_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// cond must never be true outside reset
`define ANL_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ANL_ASSERT(label, clk, rst, prop)
`define ANL_NEVER(label, clk, rst, cond)
`endif
`endif

>>> rtl/anl_pkg.sv
// Package: constants, types and the tile table for the autotile neighbour lookup.
package anl_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int X_W        = $clog2(MAX_WIDTH);
   localparam int Y_W        = $clog2(MAX_HEIGHT);
   localparam int ADDR_W     = X_W + Y_W;
   localparam int DIM_W      = 7;
   localparam int CODE_W     = 4;
   localparam int ENT_W      = 6;
   localparam int STEP_W     = 4;

   localparam logic [CODE_W-1:0] CODE_EMPTY  = 4'd0;
   localparam logic [CODE_W-1:0] CODE_FILLED = 4'd1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic REG_MAP_WIDTH  = 1'b0;
   localparam logic REG_MAP_HEIGHT = 1'b1;

   // scan positions: centre, then N NE E SE S SW W NW
   localparam logic [STEP_W-1:0] POS_CENTRE = 4'd0;
   localparam logic [STEP_W-1:0] POS_N      = 4'd1;
   localparam logic [STEP_W-1:0] POS_NE     = 4'd2;
   localparam logic [STEP_W-1:0] POS_E      = 4'd3;
   localparam logic [STEP_W-1:0] POS_SE     = 4'd4;
   localparam logic [STEP_W-1:0] POS_S      = 4'd5;
   localparam logic [STEP_W-1:0] POS_SW     = 4'd6;
   localparam logic [STEP_W-1:0] POS_W      = 4'd7;
   localparam logic [STEP_W-1:0] POS_NW     = 4'd8;
   localparam logic [STEP_W-1:0] STEP_LAST  = 4'd9;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [CODE_W-1:0] wdata;
   } mem_req_type;

   // mask -> {tile_index, rotation}; unlisted masks give tile 0, rotation 0
   function automatic logic [ENT_W-1:0] tile_lookup(input logic [7:0] mask);
      logic [ENT_W-1:0] ent;
      case (mask)
         8'd1:    ent = {4'd1, 2'd0};
         8'd4:    ent = {4'd1, 2'd1};
         8'd16:   ent = {4'd1, 2'd2};
         8'd64:   ent = {4'd1, 2'd3};
         8'd5:    ent = {4'd2, 2'd0};
         8'd20:   ent = {4'd2, 2'd1};
         8'd80:   ent = {4'd2, 2'd2};
         8'd65:   ent = {4'd2, 2'd3};
         8'd7:    ent = {4'd3, 2'd0};
         8'd28:   ent = {4'd3, 2'd1};
         8'd112:  ent = {4'd3, 2'd2};
         8'd193:  ent = {4'd3, 2'd3};
         8'd17:   ent = {4'd4, 2'd0};
         8'd68:   ent = {4'd4, 2'd2};
         8'd21:   ent = {4'd5, 2'd0};
         8'd84:   ent = {4'd5, 2'd1};
         8'd81:   ent = {4'd5, 2'd2};
         8'd69:   ent = {4'd5, 2'd3};
         8'd23:   ent = {4'd6, 2'd0};
         8'd92:   ent = {4'd6, 2'd1};
         8'd113:  ent = {4'd6, 2'd2};
         8'd197:  ent = {4'd6, 2'd3};
         8'd29:   ent = {4'd7, 2'd0};
         8'd116:  ent = {4'd7, 2'd1};
         8'd209:  ent = {4'd7, 2'd2};
         8'd71:   ent = {4'd7, 2'd3};
         8'd31:   ent = {4'd8, 2'd0};
         8'd124:  ent = {4'd8, 2'd1};
         8'd241:  ent = {4'd8, 2'd2};
         8'd199:  ent = {4'd8, 2'd3};
         8'd85:   ent = {4'd9, 2'd0};
         8'd87:   ent = {4'd10, 2'd0};
         8'd93:   ent = {4'd10, 2'd1};
         8'd117:  ent = {4'd10, 2'd2};
         8'd213:  ent = {4'd10, 2'd3};
         8'd95:   ent = {4'd11, 2'd0};
         8'd125:  ent = {4'd11, 2'd1};
         8'd245:  ent = {4'd11, 2'd2};
         8'd215:  ent = {4'd11, 2'd3};
         8'd119:  ent = {4'd12, 2'd0};
         8'd221:  ent = {4'd12, 2'd2};
         8'd127:  ent = {4'd13, 2'd0};
         8'd253:  ent = {4'd13, 2'd1};
         8'd247:  ent = {4'd13, 2'd2};
         8'd223:  ent = {4'd13, 2'd3};
         8'd255:  ent = {4'd14, 2'd0};
         default: ent = '0;
      endcase
      return ent;
   endfunction

endpackage

>>> rtl/anl_cell_ram.sv
// Single-port cell code memory with registered read.
module anl_cell_ram
   import anl_pkg::*;
(
   input  logic              clock,
   input  mem_req_type       mem_req,
   output logic [CODE_W-1:0] rd_data
);

   logic [CODE_W-1:0] mem [MAX_WIDTH*MAX_HEIGHT];

   always_ff @(posedge clock) begin
      if (mem_req.en) begin
         if (mem_req.we) begin
            mem[mem_req.addr] <= mem_req.wdata;
         end else begin
            rd_data <= mem[mem_req.addr];
         end
      end
   end

endmodule

>>> rtl/autotile_neighbour_lookup.sv
// Top level of the autotile neighbour lookup: sequencer, mask build and result register.
// The block holds a 64 x 64 grid of 4-bit cell codes in one single-port memory.
// A write transaction stores one code; it gives no result.
// A query transaction for a cell inside the map reads the centre cell and its
// eight neighbours one per cycle through the memory port, builds the 8-bit
// neighbour mask, looks the tile up and loads the result register.
// A query outside the map skips the scan and gives an error result. Neighbours
// outside the map are not read and count as empty. The result register lets the
// next transaction enter while an earlier result waits on rsp_tready; a query
// that finishes before that result is taken waits in its last state.
// The user must write map_width and map_height through the csr port only while idle; the block does not enforce it.
`include "autotile_neighbour_lookup_macros.svh"

module autotile_neighbour_lookup
   import anl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // query / write channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // cell_x[5:0], cell_y[11:6], cell_value[15:12]
   input  logic        req_tuser,   // op: 0 write, 1 query
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // tile_index[3:0], rotation[5:4], neighbour_mask[13:6], 0
   output logic        rsp_tuser,  // coord_error
   // register write port
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [6:0]  csr_data
);

   // ---- register file ----
   logic [DIM_W-1:0] map_width_ff, map_width_in;
   logic [DIM_W-1:0] map_height_ff, map_height_in;

   assign csr_ready = 1'b1;

   always_comb begin
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MAP_WIDTH:  map_width_in  = csr_data;
            REG_MAP_HEIGHT: map_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= DIM_W'(MAX_WIDTH);
         map_height_ff <= DIM_W'(MAX_HEIGHT);
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
      end
   end

   // ---- input fields ----
   logic [X_W-1:0]    req_x;
   logic [Y_W-1:0]    req_y;
   logic [CODE_W-1:0] req_value;
   logic              req_acc;
   logic              query_acc;
   logic              req_err;

   assign req_x     = req_tdata[X_W-1:0];
   assign req_y     = req_tdata[X_W+Y_W-1:X_W];
   assign req_value = req_tdata[X_W+Y_W+CODE_W-1:X_W+Y_W];
   assign req_acc   = req_tvalid && req_tready;
   assign query_acc = req_acc && (req_tuser == OP_QUERY);
   // coordinates always lie below 64, so comparing with the raw register also
   // covers sizes above the store
   assign req_err   = ({1'b0, req_x} >= map_width_ff) || ({1'b0, req_y} >= map_height_ff);

   // ---- sequencer state ----
   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [X_W-1:0]    x_ff, x_in;
   logic [Y_W-1:0]    y_ff, y_in;
   logic              err_ff, err_in;
   logic              out_free;
   logic              scan_issue;

   assign out_free   = !rsp_tvalid || rsp_tready;
   assign scan_issue = (state_ff == ST_SCAN) && (step_ff != STEP_LAST);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_tuser == OP_QUERY)) begin
               state_in = req_err ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      step_in    = step_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      err_in     = err_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            step_in    = '0;
            if (req_acc) begin
               x_in   = req_x;
               y_in   = req_y;
               err_in = req_err;
            end
         end
         ST_SCAN: step_in = step_ff + STEP_W'(1);
         ST_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      err_ff <= err_in;
   end

   // ---- neighbour address generation ----
   logic           x_lo_ok, x_hi_ok, y_lo_ok, y_hi_ok;
   logic [X_W-1:0] x_dec, x_inc;
   logic [Y_W-1:0] y_dec, y_inc;
   logic [X_W-1:0] pos_x;
   logic [Y_W-1:0] pos_y;
   logic           pos_ok;

   assign x_dec   = x_ff - X_W'(1);
   assign x_inc   = x_ff + X_W'(1);
   assign y_dec   = y_ff - Y_W'(1);
   assign y_inc   = y_ff + Y_W'(1);
   assign x_lo_ok = (x_ff != '0);
   assign y_lo_ok = (y_ff != '0);
   // the last store column or row has nothing beyond it, even when the
   // register asks for a larger map
   assign x_hi_ok = (x_ff != '1) && (({1'b0, x_ff} + DIM_W'(1)) < map_width_ff);
   assign y_hi_ok = (y_ff != '1) && (({1'b0, y_ff} + DIM_W'(1)) < map_height_ff);

   always_comb begin
      pos_x  = x_ff;
      pos_y  = y_ff;
      pos_ok = 1'b1;
      case (step_ff)
         POS_CENTRE: ;
         POS_N: begin
            pos_y = y_dec; pos_ok = y_lo_ok;
         end
         POS_NE: begin
            pos_x = x_inc; pos_y = y_dec; pos_ok = x_hi_ok && y_lo_ok;
         end
         POS_E: begin
            pos_x = x_inc; pos_ok = x_hi_ok;
         end
         POS_SE: begin
            pos_x = x_inc; pos_y = y_inc; pos_ok = x_hi_ok && y_hi_ok;
         end
         POS_S: begin
            pos_y = y_inc; pos_ok = y_hi_ok;
         end
         POS_SW: begin
            pos_x = x_dec; pos_y = y_inc; pos_ok = x_lo_ok && y_hi_ok;
         end
         POS_W: begin
            pos_x = x_dec; pos_ok = x_lo_ok;
         end
         POS_NW: begin
            pos_x = x_dec; pos_y = y_dec; pos_ok = x_lo_ok && y_lo_ok;
         end
         default: pos_ok = 1'b0;
      endcase
   end

   // ---- cell memory ----
   mem_req_type       mem_req;
   logic [CODE_W-1:0] rd_data;

   always_comb begin
      mem_req = '0;
      if ((state_ff == ST_IDLE) && req_acc && (req_tuser == OP_WRITE)) begin
         mem_req.en    = 1'b1;
         mem_req.we    = 1'b1;
         mem_req.addr  = {req_y, req_x};
         mem_req.wdata = req_value;
      end else if (scan_issue && pos_ok) begin
         mem_req.en   = 1'b1;
         mem_req.addr = {pos_y, pos_x};
      end
   end

   anl_cell_ram u_cell_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // ---- read-data capture, in the cycle after the issue ----
   logic              rd_live_ff;
   logic [STEP_W-1:0] rd_pos_ff;
   logic              rd_inmap_ff;
   logic [2:0]        nb_slot;
   logic [7:0]        nb_ff;
   logic              centre_nz_ff;

   assign nb_slot = 3'(rd_pos_ff - POS_N);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_live_ff <= 1'b0;
      end else begin
         rd_live_ff <= scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      rd_pos_ff   <= step_ff;
      rd_inmap_ff <= pos_ok;
      if (rd_live_ff) begin
         if (rd_pos_ff == POS_CENTRE) begin
            centre_nz_ff <= (rd_data != CODE_EMPTY);
         end else begin
            nb_ff[nb_slot] <= rd_inmap_ff && (rd_data == CODE_FILLED);
         end
      end
   end

   // ---- mask build and table lookup ----
   // nb_ff bits: 0 N, 1 NE, 2 E, 3 SE, 4 S, 5 SW, 6 W, 7 NW
   logic [7:0]       mask;
   logic [ENT_W-1:0] ent;

   always_comb begin
      mask    = '0;
      mask[0] = nb_ff[0];
      mask[1] = nb_ff[0] && nb_ff[1] && nb_ff[2];
      mask[2] = nb_ff[2];
      mask[3] = nb_ff[2] && nb_ff[3] && nb_ff[4];
      mask[4] = nb_ff[4];
      mask[5] = nb_ff[4] && nb_ff[5] && nb_ff[6];
      mask[6] = nb_ff[6];
      mask[7] = nb_ff[6] && nb_ff[7] && nb_ff[0];
      if (!centre_nz_ff) begin
         mask = '0;   // empty centre picks table entry 0
      end
   end

   assign ent = tile_lookup(mask);

   // ---- result register ----
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;
   logic        rsp_err_ff, rsp_err_in;
   logic        rsp_load;

   assign rsp_load = (state_ff == ST_DONE) && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_err_in   = err_ff;
         rsp_data_in  = err_ff ? 16'd0 : {2'b00, mask, ent[1:0], ent[ENT_W-1:2]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

   // ---- assertions ----
   `ANL_NEVER(a_step_bound, clock, reset, (state_ff == ST_SCAN) && (step_ff > STEP_LAST))
   `ANL_ASSERT(a_query_leaves_idle, clock, reset, query_acc |=> (state_ff != ST_IDLE))
   `ANL_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
   `ANL_NEVER(a_write_outside_idle, clock, reset, mem_req.en && mem_req.we && (state_ff != ST_IDLE))

endmodule
